FILE: rtl/core/cosine_sum_window_gen_assert.svh
// assertion macros for the cosine-sum window generator
// included by the top level, no other dependencies
`ifndef COSINE_SUM_WINDOW_GEN_ASSERT_SVH
`define COSINE_SUM_WINDOW_GEN_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CSW_ASSERT_IMPLY(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);
`define CSW_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSW_ASSERT_IMPLY(label, clk, dis, ante, cons, msg)
`define CSW_ASSERT_NEXT(label, clk, dis, ante, cons, msg)
`endif
`endif

FILE: rtl/core/csw_pkg.sv
// shared types and constants of the cosine-sum window generator
// no dependencies
`default_nettype none
package csw_pkg;
    localparam int TAP_W  = 12;
    localparam int LEN_W  = 13;
    localparam int COEF_W = 18;
    localparam int VAL_W  = 18;
    localparam int IDX_W  = 3;
    localparam int COS_W  = 18;
    localparam int PROD_W = 36;
    localparam int ACC_W  = 40;

    typedef enum logic [IDX_W-1:0] {
        REG_NUM_TAPS   = 3'd0,
        REG_COEF_ZERO  = 3'd1,
        REG_COEF_ONE   = 3'd2,
        REG_COEF_TWO   = 3'd3,
        REG_COEF_THREE = 3'd4,
        REG_COEF_FOUR  = 3'd5
    } cfg_idx_t;

    // side info that travels with each beat
    typedef struct packed {
        logic vld;
        logic oor;
        logic flat;
    } meta_t;
endpackage
`default_nettype wire

FILE: rtl/core/cosine_sum_window_gen.sv
// top level of the cosine-sum window generator
// depends on csw_pkg, csw_phase_div, csw_cos_lane, csw_mac, assertion header
//
// usage:
//   s_ channel: one beat carries a tap index (s_tdata[11:0]); one result per beat
//   m_ channel: m_tdata[17:0] window value, signed q1.16, saturated;
//               m_tuser[0] index error (index not below the window length, value 0)
//   cfg channel: cfg_index selects num_taps, c0..c4; cfg_ready is always high;
//               write only while no beat is in flight
//   latency: log2(COS_TABLE_DEPTH) + 11 cycles from accept to m_tvalid
//            (21 at the default depth): one input stage, one divider stage per
//            phase bit plus one, three lane stages, three sum stages, output
//   throughput: one beat per cycle; the divider is fully pipelined, each
//               harmonic has its own rom copy
//   stall: while m_tvalid is high and m_tready low the whole pipeline freezes,
//          s_tready drops with it, nothing is lost or repeated
//   reset: aresetn low clears all valid bits and loads the hann preset, length 64
`default_nettype none
`include "cosine_sum_window_gen_assert.svh"
module cosine_sum_window_gen #(
    parameter int MAX_TAPS        = 4096,
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // slave: tap_index [11:0], zero pad [15:12]
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,
    // master: window_value [17:0], zero pad [23:18]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [23:0]                        m_tdata,
    // master: index_error [0]
    output logic [0:0]                         m_tuser,
    // configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [csw_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [csw_pkg::COEF_W-1:0]    cfg_data
);
    localparam int LD      = $clog2(COS_TABLE_DEPTH);
    localparam int PH_W    = LD + 2;
    localparam int LW      = csw_pkg::LEN_W;
    localparam int CWD     = csw_pkg::COEF_W;
    localparam int LEN_CAP = (MAX_TAPS > 8191) ? 8191 : MAX_TAPS;
    localparam int TAIL    = 6;  // lane plus sum stages

    // config registers
    logic [LW-1:0]         num_taps_reg;
    logic signed [CWD-1:0] coef_zero_reg, coef_one_reg, coef_two_reg;
    logic signed [CWD-1:0] coef_three_reg, coef_four_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_taps_reg   <= LW'(64);
            coef_zero_reg  <= 18'sd32768;
            coef_one_reg   <= 18'sd32768;
            coef_two_reg   <= '0;
            coef_three_reg <= '0;
            coef_four_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                csw_pkg::REG_NUM_TAPS:   num_taps_reg   <= cfg_data[LW-1:0];
                csw_pkg::REG_COEF_ZERO:  coef_zero_reg  <= cfg_data;
                csw_pkg::REG_COEF_ONE:   coef_one_reg   <= cfg_data;
                csw_pkg::REG_COEF_TWO:   coef_two_reg   <= cfg_data;
                csw_pkg::REG_COEF_THREE: coef_three_reg <= cfg_data;
                csw_pkg::REG_COEF_FOUR:  coef_four_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective length and phase span
    logic [LW-1:0] len;
    logic [LW-1:0] m_span;
    assign len    = (num_taps_reg > LW'(LEN_CAP)) ? LW'(LEN_CAP) : num_taps_reg;
    assign m_span = LW'(len - LW'(1));

    // global advance: frozen only when a result waits on a stalled receiver
    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // input stage
    logic [csw_pkg::TAP_W-1:0] tap_reg;
    csw_pkg::meta_t            in_meta_reg;
    csw_pkg::meta_t            in_meta_next;

    always_comb begin
        in_meta_next.vld  = s_tvalid;
        in_meta_next.oor  = {1'b0, s_tdata[csw_pkg::TAP_W-1:0]} >= len;
        in_meta_next.flat = len < LW'(2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_meta_reg <= '0;
        end else if (en) begin
            in_meta_reg <= in_meta_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg <= s_tdata[csw_pkg::TAP_W-1:0];
        end
    end

    // phase: quotient and remainder of n * 4 * depth / (len - 1)
    logic [PH_W:0]  div_quo;
    logic [LW-1:0]  div_rem;
    csw_pkg::meta_t div_meta;

    csw_phase_div #(.PH_W(PH_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .n_in     ({1'b0, tap_reg}),
        .m_span   (m_span),
        .meta_in  (in_meta_reg),
        .quo_out  (div_quo),
        .rem_out  (div_rem),
        .meta_out (div_meta)
    );

    // one lane per harmonic
    logic signed [csw_pkg::COS_W-1:0] cos_h [1:4];

    for (genvar k = 1; k <= 4; k++) begin : g_lane
        csw_cos_lane #(.DEPTH(COS_TABLE_DEPTH), .HARM(k)) u_lane (
            .aclk    (aclk),
            .en      (en),
            .q_in    (div_quo),
            .r_in    (div_rem),
            .m_span  (m_span),
            .flat    (div_meta.flat),
            .cos_out (cos_h[k])
        );
    end

    logic signed [csw_pkg::VAL_W-1:0] mac_value;

    csw_mac u_mac (
        .aclk       (aclk),
        .en         (en),
        .coef_zero  (coef_zero_reg),
        .coef_one   (coef_one_reg),
        .coef_two   (coef_two_reg),
        .coef_three (coef_three_reg),
        .coef_four  (coef_four_reg),
        .cos_one    (cos_h[1]),
        .cos_two    (cos_h[2]),
        .cos_three  (cos_h[3]),
        .cos_four   (cos_h[4]),
        .value_out  (mac_value)
    );

    // side info follows the lane and sum stages
    csw_pkg::meta_t tail_meta_reg [0:TAIL-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAIL; i++) tail_meta_reg[i] <= '0;
        end else if (en) begin
            tail_meta_reg[0] <= div_meta;
            for (int i = 1; i < TAIL; i++) tail_meta_reg[i] <= tail_meta_reg[i-1];
        end
    end

    // output register
    logic [csw_pkg::VAL_W-1:0] value_reg;
    logic                      err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= tail_meta_reg[TAIL-1].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= tail_meta_reg[TAIL-1].oor ? '0 : mac_value;
            err_reg   <= tail_meta_reg[TAIL-1].oor;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, value_reg};
    assign m_tuser  = err_reg;

    // an error beat always carries a zero value
    `CSW_ASSERT_IMPLY(a_err_zero, aclk, !aresetn, m_tvalid && m_tuser[0], m_tdata == 24'd0, "index error beat with nonzero value")
    // divider remainder stays below the span for in-range items
    `CSW_ASSERT_IMPLY(a_rem_bound, aclk, !aresetn, div_meta.vld && !div_meta.oor && !div_meta.flat, div_rem < m_span, "divider remainder out of bound")
    // nothing is offered right after reset
    `CSW_ASSERT_NEXT(a_reset_quiet, aclk, 1'b0, !aresetn, !m_tvalid, "output valid right after reset")
endmodule
`default_nettype wire

FILE: rtl/core/csw_phase_div.sv
// pipelined restoring divider: q = floor(n * 2^PH_W / m), one quotient bit per stage
// depends on csw_pkg
`default_nettype none
module csw_phase_div #(
    parameter int PH_W = 12
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic [csw_pkg::LEN_W-1:0]   n_in,
    input  wire logic [csw_pkg::LEN_W-1:0]   m_span,
    input  wire csw_pkg::meta_t              meta_in,
    output logic [PH_W:0]                    quo_out,
    output logic [csw_pkg::LEN_W-1:0]        rem_out,
    output csw_pkg::meta_t                   meta_out
);
    localparam int RW = csw_pkg::LEN_W;

    logic [RW-1:0]   rem_reg  [0:PH_W];
    logic [PH_W:0]   quo_reg  [0:PH_W];
    csw_pkg::meta_t  meta_reg [0:PH_W];

    // first stage settles the integer bit (n not below m)
    logic          ge0;
    logic [RW-1:0] rem0_next;
    assign ge0       = n_in >= m_span;
    assign rem0_next = ge0 ? RW'(n_in - m_span) : n_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_reg[0] <= '0;
        end else if (en) begin
            meta_reg[0] <= meta_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= rem0_next;
            quo_reg[0] <= {{PH_W{1'b0}}, ge0};
        end
    end

    for (genvar i = 1; i <= PH_W; i++) begin : g_stage
        logic [RW:0]   dbl;
        logic          ge;
        logic [RW-1:0] rem_next;
        assign dbl      = {rem_reg[i-1], 1'b0};
        assign ge       = dbl >= {1'b0, m_span};
        assign rem_next = ge ? RW'(dbl - {1'b0, m_span}) : RW'(dbl);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                meta_reg[i] <= '0;
            end else if (en) begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= rem_next;
                quo_reg[i] <= {quo_reg[i-1][PH_W-1:0], ge};
            end
        end
    end

    assign quo_out  = quo_reg[PH_W];
    assign rem_out  = rem_reg[PH_W];
    assign meta_out = meta_reg[PH_W];
endmodule
`default_nettype wire

FILE: rtl/core/csw_cos_lane.sv
// one harmonic lane: phase rounding, quadrant fold and quarter-wave rom read
// depends on csw_pkg
`default_nettype none
module csw_cos_lane #(
    parameter int DEPTH = 1024,
    parameter int HARM  = 1
) (
    input  wire logic                             aclk,
    input  wire logic                             en,
    input  wire logic [$clog2(DEPTH)+2:0]         q_in,
    input  wire logic [csw_pkg::LEN_W-1:0]        r_in,
    input  wire logic [csw_pkg::LEN_W-1:0]        m_span,
    input  wire logic                             flat,
    output logic signed [csw_pkg::COS_W-1:0]      cos_out
);
    localparam int LD   = $clog2(DEPTH);
    localparam int PH_W = LD + 2;
    localparam int AW   = LD + 1;
    localparam int CW   = csw_pkg::LEN_W + 4;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    typedef logic [16:0] rom_t [0:DEPTH];

    // restoring long division for the table build
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic longint cos_q30(input longint unsigned theta);
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x2   = (theta * theta) >> 30;
        term = ONE_Q30;
        acc  = longint'(ONE_Q30);
        for (int k = 1; k <= 12; k++) begin
            term = udiv64((term * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
            if ((k & 1) == 1) acc = acc - longint'(term);
            else              acc = acc + longint'(term);
        end
        return acc;
    endfunction

    function automatic rom_t build_rom();
        rom_t   rom;
        longint c;
        for (int i = 0; i <= DEPTH; i++) begin
            c = cos_q30(udiv64(HALF_PI_Q30 * 64'(i), 64'(DEPTH)));
            if (c < 0) c = 0;
            rom[i] = 17'((c + 8192) >> 14);
        end
        rom[0]     = 17'd65536;
        rom[DEPTH] = 17'd0;
        return rom;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    // rounding carry of k*rem/m, 0..4
    logic [CW-1:0]   rk;
    logic [2:0]      carry;
    logic [PH_W-1:0] kq;
    logic [PH_W-1:0] phase_next;
    assign rk = CW'(r_in) * CW'(2 * HARM);
    assign kq = PH_W'(q_in) * PH_W'(HARM);

    always_comb begin
        carry = '0;
        for (int j = 1; j <= 4; j++) begin
            if (rk >= CW'(m_span) * CW'(2 * j - 1)) carry = carry + 3'd1;
        end
    end
    assign phase_next = flat ? '0 : PH_W'(kq + PH_W'(carry));

    logic [PH_W-1:0] phase_reg;
    logic [AW-1:0]   addr_reg;
    logic            neg_reg;
    logic [16:0]     rom_reg;
    logic            neg2_reg;

    logic [1:0]      quad;
    logic [LD-1:0]   frac;
    logic [AW-1:0]   addr_next;
    assign quad      = phase_reg[PH_W-1:PH_W-2];
    assign frac      = phase_reg[LD-1:0];
    assign addr_next = quad[0] ? AW'(AW'(DEPTH) - {1'b0, frac}) : {1'b0, frac};

    always_ff @(posedge aclk) begin
        if (en) begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            neg_reg   <= quad[0] ^ quad[1];
            rom_reg   <= COS_ROM[addr_reg];
            neg2_reg  <= neg_reg;
        end
    end

    assign cos_out = neg2_reg ? -$signed({1'b0, rom_reg}) : $signed({1'b0, rom_reg});
endmodule
`default_nettype wire

FILE: rtl/core/csw_mac.sv
// weighted harmonic sum: multiply, two add stages, round and saturate
// depends on csw_pkg
`default_nettype none
module csw_mac (
    input  wire logic                               aclk,
    input  wire logic                               en,
    input  wire logic signed [csw_pkg::COEF_W-1:0]  coef_zero,
    input  wire logic signed [csw_pkg::COEF_W-1:0]  coef_one,
    input  wire logic signed [csw_pkg::COEF_W-1:0]  coef_two,
    input  wire logic signed [csw_pkg::COEF_W-1:0]  coef_three,
    input  wire logic signed [csw_pkg::COEF_W-1:0]  coef_four,
    input  wire logic signed [csw_pkg::COS_W-1:0]   cos_one,
    input  wire logic signed [csw_pkg::COS_W-1:0]   cos_two,
    input  wire logic signed [csw_pkg::COS_W-1:0]   cos_three,
    input  wire logic signed [csw_pkg::COS_W-1:0]   cos_four,
    output logic signed [csw_pkg::VAL_W-1:0]        value_out
);
    localparam int PW = csw_pkg::PROD_W;
    localparam int SW = csw_pkg::PROD_W + 2;
    localparam int AW = csw_pkg::ACC_W;

    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [SW-1:0] a_reg, b_reg;
    logic signed [PW-1:0] c_reg;
    logic signed [AW-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg  <= PW'(coef_zero) <<< 16;
            p1_reg  <= coef_one   * cos_one;
            p2_reg  <= coef_two   * cos_two;
            p3_reg  <= coef_three * cos_three;
            p4_reg  <= coef_four  * cos_four;
            a_reg   <= SW'(p0_reg) - SW'(p1_reg);
            b_reg   <= SW'(p2_reg) - SW'(p3_reg);
            c_reg   <= p4_reg;
            acc_reg <= AW'(a_reg) + AW'(b_reg) + AW'(c_reg);
        end
    end

    // round half up to q1.16, then clamp
    logic signed [AW-1:0] rnd;
    logic signed [AW-1:0] shifted;
    assign rnd     = acc_reg + AW'(32768);
    assign shifted = rnd >>> 16;

    always_comb begin
        if (shifted > AW'(131071)) begin
            value_out = 18'sd131071;
        end else if (shifted < -AW'(131072)) begin
            value_out = -18'sd131072;
        end else begin
            value_out = csw_pkg::VAL_W'(shifted);
        end
    end
endmodule
`default_nettype wire
